@@ hw/rtl/iws_pkg.sv @@
// Shared constants, types and the reset curve for the interpolating waveshaper.
// No dependencies; imported by iws_table, iws_blend, interpolating_waveshaper and tb.
`timescale 1ns / 1ps

package iws_pkg;

	localparam int TABLE_DEPTH = 129;
	localparam int TABLE_LAST  = 128;
	localparam int IDX_W       = 8;
	localparam int SEG_W       = 7;
	localparam int FRAC_W      = 9;
	localparam int SAMPLE_W    = 16;
	localparam int GLITCH_W    = 3;
	localparam int SHIFT_W     = 4;
	localparam int WEIGHT_W    = FRAC_W + 1;
	localparam int ACC_W       = SAMPLE_W + WEIGHT_W;
	localparam int PEAK        = 32767;

	localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 16'h8000;

	// Input item codes
	localparam logic ACT_SHAPE = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	typedef logic [SAMPLE_W-1:0] curve_arr_t [TABLE_DEPTH];

	// Registered read result of the two neighboring curve points
	typedef struct packed {
		logic [SAMPLE_W-1:0] lo_data;
		logic [SAMPLE_W-1:0] hi_data;
		logic                lo_hit;
		logic                hi_hit;
	} tbl_rd_t;

	// Mild saturation curve: quadratic toward the bottom and top rails
	function automatic curve_arr_t build_curve();
		curve_arr_t arr;
		int v;
		int d;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (i < 64) begin
				v = ((i * i * PEAK) >>> 12) - PEAK;
			end else begin
				d = TABLE_LAST - i;
				v = PEAK - ((d * d * PEAK) >>> 12);
			end
			arr[i] = v[SAMPLE_W-1:0];
		end
		return arr;
	endfunction

	localparam curve_arr_t CURVE_ROM = build_curve();

endpackage

@@ hw/rtl/iws_table.sv @@
// Curve point memory with one write port and two registered read ports.
// Per-entry fill bits mark points rewritten since reset. Depends on iws_pkg.
`timescale 1ns / 1ps

module iws_table import iws_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_index,
	input  logic [SAMPLE_W-1:0] wr_value,
	input  logic                rd_en,
	input  logic [SEG_W-1:0]    rd_index,
	output tbl_rd_t             rd
);

	logic [SAMPLE_W-1:0]    mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] filled_q;
	logic [IDX_W-1:0]       lo_addr;
	logic [IDX_W-1:0]       hi_addr;
	logic                   wr_ok;
	logic [SAMPLE_W-1:0]    lo_data_s1;
	logic [SAMPLE_W-1:0]    hi_data_s1;
	logic                   lo_hit_s1;
	logic                   hi_hit_s1;

	assign lo_addr = {1'b0, rd_index};
	assign hi_addr = lo_addr + IDX_W'(1);
	assign wr_ok   = wr_en && (wr_index <= IDX_W'(TABLE_LAST));

	// Write one point, read both segment ends
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wr_index] <= wr_value;
		end
		if (rd_en) begin
			lo_data_s1 <= mem[lo_addr];
			hi_data_s1 <= mem[hi_addr];
		end
	end

	// Track rewritten points; a point not yet rewritten reads from the reset curve
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q  <= '0;
			lo_hit_s1 <= 1'b0;
			hi_hit_s1 <= 1'b0;
		end else begin
			if (wr_ok) begin
				filled_q[wr_index] <= 1'b1;
			end
			if (rd_en) begin
				lo_hit_s1 <= filled_q[lo_addr];
				hi_hit_s1 <= filled_q[hi_addr];
			end
		end
	end

	// Bundle the registered read result
	assign rd = '{lo_data: lo_data_s1, hi_data: hi_data_s1,
		lo_hit: lo_hit_s1, hi_hit: hi_hit_s1};

endmodule

@@ hw/rtl/iws_blend.sv @@
// Linear blend of two curve points by the sample's low position bits.
// Combinational; depends on iws_pkg for the reset curve and widths.
`timescale 1ns / 1ps

module iws_blend import iws_pkg::*; (
	input  tbl_rd_t             rd,
	input  logic [SEG_W-1:0]    seg,
	input  logic [FRAC_W-1:0]   frac,
	input  logic [GLITCH_W-1:0] glitch,
	output logic [SAMPLE_W-1:0] shaped
);

	logic [IDX_W-1:0]    lo_idx;
	logic [IDX_W-1:0]    hi_idx;
	logic [SAMPLE_W-1:0] lo_pt;
	logic [SAMPLE_W-1:0] hi_pt;
	logic [SHIFT_W-1:0]  shift;
	logic [WEIGHT_W-1:0] one;
	logic [WEIGHT_W-1:0] frac_used;
	logic [WEIGHT_W-1:0] lo_wt;
	logic [ACC_W-1:0]    acc;
	logic [ACC_W-1:0]    acc_sh;

	// Pick the stored point or the reset curve point
	assign lo_idx = {1'b0, seg};
	assign hi_idx = lo_idx + IDX_W'(1);
	assign lo_pt  = rd.lo_hit ? rd.lo_data : CURVE_ROM[lo_idx];
	assign hi_pt  = rd.hi_hit ? rd.hi_data : CURVE_ROM[hi_idx];

	// Fraction width shrinks with the glitch setting
	assign shift     = SHIFT_W'(FRAC_W) - {1'b0, glitch};
	assign one       = WEIGHT_W'(1) << shift;
	assign frac_used = {1'b0, frac} & (one - WEIGHT_W'(1));
	assign lo_wt     = one - frac_used;

	// Blend in offset-binary so the right shift floors
	assign acc    = ACC_W'(lo_pt ^ SIGN_FLIP) * ACC_W'(lo_wt)
		+ ACC_W'(hi_pt ^ SIGN_FLIP) * ACC_W'(frac_used);
	assign acc_sh = acc >> shift;
	assign shaped = acc_sh[SAMPLE_W-1:0] ^ SIGN_FLIP;

endmodule

@@ hw/rtl/interpolating_waveshaper.sv @@
// Top level of the interpolating waveshaper: handshakes, pipeline and config register.
// Depends on iws_pkg, iws_table and iws_blend.
`timescale 1ns / 1ps
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | in_valid / in_stall    | action, sample_in, entry_index, entry_value
//  out     | output    | out_valid / out_stall  | sample_out
//  cfg     | input     | cfg_valid / cfg_ready  | glitch_amount
//
//  One transaction per cycle while in_stall is low. A shape transaction passes through
//  the table read register, then the blend and output register, to sample_out.
//  A table write yields no result and lands in the memory at its accept edge.
//  in_stall rises only when both the read stage and the output register hold data
//  and out_stall is high. Reset clears the config and restores the reset curve at once.

module interpolating_waveshaper import iws_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                action,
	input  logic [SAMPLE_W-1:0] sample_in,
	input  logic [IDX_W-1:0]    entry_index,
	input  logic [SAMPLE_W-1:0] entry_value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [SAMPLE_W-1:0] sample_out,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [GLITCH_W-1:0] glitch_amount
);

	logic [GLITCH_W-1:0] glitch_q;
	logic                s1_valid_q;
	logic [SEG_W-1:0]    seg_s1;
	logic [FRAC_W-1:0]   frac_s1;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] sample_out_q;
	logic                s2_adv;
	logic                in_fire;
	logic                shape_fire;
	logic                write_fire;
	logic [SAMPLE_W-1:0] pos;
	logic [SAMPLE_W-1:0] shaped;
	tbl_rd_t             rd;

	// Handshake control
	assign s2_adv     = !out_valid_q || !out_stall;
	assign in_stall   = s1_valid_q && !s2_adv;
	assign in_fire    = in_valid && !in_stall;
	assign shape_fire = in_fire && (action == ACT_SHAPE);
	assign write_fire = in_fire && (action == ACT_WRITE);
	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// Offset the sample to an unsigned position
	assign pos = sample_in ^ SIGN_FLIP;

	// Hold the glitch setting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glitch_q <= '0;
		end else if (cfg_valid) begin
			glitch_q <= glitch_amount;
		end
	end

	iws_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (write_fire),
		.wr_index (entry_index),
		.wr_value (entry_value),
		.rd_en    (shape_fire),
		.rd_index (pos[SAMPLE_W-1:FRAC_W]),
		.rd       (rd)
	);

	// Advance the read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= shape_fire;
		end
	end

	// Capture segment and fraction alongside the table read
	always_ff @(posedge clk) begin
		if (shape_fire) begin
			seg_s1  <= pos[SAMPLE_W-1:FRAC_W];
			frac_s1 <= pos[FRAC_W-1:0];
		end
	end

	iws_blend u_blend (
		.rd     (rd),
		.seg    (seg_s1),
		.frac   (frac_s1),
		.glitch (glitch_q),
		.shaped (shaped)
	);

	// Output register: load when free or drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv && s1_valid_q) begin
			sample_out_q <= shaped;
		end
	end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for interpolating_waveshaper: a stimulus table, then random phases.
// Depends on iws_pkg and the RTL. Keeps its own curve table and glitch setting to compute outputs.
`timescale 1ns / 1ps

module tb;
	import iws_pkg::*;

	localparam int N_ROWS      = 21;
	localparam int N_PHASES    = 10;
	localparam int PHASE_ITEMS = 180;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic                act;
		logic [SAMPLE_W-1:0] smp;
		logic [IDX_W-1:0]    idx;
		logic [SAMPLE_W-1:0] val;
		logic                typed;
		logic [SAMPLE_W-1:0] want;
	} stim_row_t;

	// Opening stimulus: rails, center, table writes at both ends, ignored writes.
	// Rows with typed set carry a precomputed expected output; the others are checked against shape_sample.
	localparam stim_row_t STIM_ROWS [N_ROWS] = '{
		'{ACT_SHAPE, 16'h8000, 8'd0,   16'h0000, 1'b1, 16'h8001},
		'{ACT_SHAPE, 16'h7FFF, 8'd0,   16'h0000, 1'b1, 16'h7FFE},
		'{ACT_SHAPE, 16'h0000, 8'd0,   16'h0000, 1'b1, 16'h0000},
		'{ACT_SHAPE, 16'hFFFF, 8'd0,   16'h0000, 1'b0, 16'h0000},
		'{ACT_SHAPE, 16'h0001, 8'd0,   16'h0000, 1'b0, 16'h0000},
		'{ACT_SHAPE, 16'h0100, 8'd0,   16'h0000, 1'b0, 16'h0000},
		'{ACT_SHAPE, 16'h5555, 8'hAA,  16'h5555, 1'b0, 16'h0000},
		'{ACT_SHAPE, 16'hAAAA, 8'h55,  16'hAAAA, 1'b0, 16'h0000},
		'{ACT_WRITE, 16'h0000, 8'd0,   16'h1234, 1'b0, 16'h0000},
		'{ACT_SHAPE, 16'h8000, 8'd0,   16'h0000, 1'b1, 16'h1234},
		'{ACT_WRITE, 16'hFFFF, 8'd128, 16'h8000, 1'b0, 16'h0000},
		'{ACT_SHAPE, 16'h7FFF, 8'd0,   16'h0000, 1'b0, 16'h0000},
		'{ACT_WRITE, 16'h0000, 8'd129, 16'h0000, 1'b0, 16'h0000},
		'{ACT_WRITE, 16'h0000, 8'd255, 16'hFFFF, 1'b0, 16'h0000},
		'{ACT_SHAPE, 16'h8000, 8'd0,   16'h0000, 1'b1, 16'h1234},
		'{ACT_WRITE, 16'h0000, 8'd64,  16'h7FFF, 1'b0, 16'h0000},
		'{ACT_SHAPE, 16'h0000, 8'd0,   16'h0000, 1'b1, 16'h7FFF},
		'{ACT_WRITE, 16'h0000, 8'd65,  16'h8000, 1'b0, 16'h0000},
		'{ACT_SHAPE, 16'h0100, 8'd0,   16'h0000, 1'b0, 16'h0000},
		'{ACT_WRITE, 16'h0000, 8'd1,   16'h7FFF, 1'b0, 16'h0000},
		'{ACT_SHAPE, 16'h81FF, 8'd0,   16'h0000, 1'b0, 16'h0000}
	};

	localparam logic [GLITCH_W-1:0] GLITCH_PLAN [N_PHASES] = '{
		3'd7, 3'd0, 3'd4, 3'd2, 3'd7, 3'd1, 3'd6, 3'd3, 3'd5, 3'd0
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                action = ACT_SHAPE;
	logic [SAMPLE_W-1:0] sample_in = '0;
	logic [IDX_W-1:0]    entry_index = '0;
	logic [SAMPLE_W-1:0] entry_value = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [SAMPLE_W-1:0] sample_out;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [GLITCH_W-1:0] glitch_amount = '0;

	// Shadow of the block: curve points, glitch setting, outputs still owed
	logic [SAMPLE_W-1:0] curve_pts [TABLE_DEPTH];
	logic [GLITCH_W-1:0] glitch_now;
	logic [SAMPLE_W-1:0] pending_shapes [$];
	logic [SAMPLE_W-1:0] owed;
	int                  mismatches = 0;
	bit                  calm = 1'b0;
	bit                  hold_req = 1'b0;

	always #5 clk = ~clk;

	interpolating_waveshaper u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.sample_in    (sample_in),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_out   (sample_out),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.glitch_amount(glitch_amount)
	);

	// Load the mild saturation curve into the shadow table and clear the shadow glitch setting
	task automatic load_reset_curve();
		int d;
		int q;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			d = (i < 64) ? i : TABLE_LAST - i;
			q = (d * d * PEAK) >>> 12;
			curve_pts[i] = (i < 64) ? SAMPLE_W'(q - PEAK) : SAMPLE_W'(PEAK - q);
		end
		glitch_now = '0;
	endtask

	// Blend the two neighboring curve points on the biased (unsigned) scale
	function automatic logic [SAMPLE_W-1:0] shape_sample(logic [SAMPLE_W-1:0] smp);
		logic [SAMPLE_W-1:0] pos;
		int unsigned         seg;
		int unsigned         fbits;
		int unsigned         unit;
		int unsigned         frac;
		int unsigned         lo;
		int unsigned         hi;
		int unsigned         acc;
		pos   = smp ^ SIGN_FLIP;
		seg   = pos >> FRAC_W;
		fbits = FRAC_W - glitch_now;
		unit  = 1 << fbits;
		frac  = pos & (unit - 1);
		lo    = {16'h0, curve_pts[seg] ^ SIGN_FLIP};
		hi    = {16'h0, curve_pts[seg + 1] ^ SIGN_FLIP};
		acc   = lo * (unit - frac) + hi * frac;
		return SAMPLE_W'(acc >> fbits) ^ SIGN_FLIP;
	endfunction

	// Offer one transaction after any random idle gap, hold it until accepted, then update the shadow
	task automatic offer_item(logic act, logic [SAMPLE_W-1:0] smp, logic [IDX_W-1:0] idx,
			logic [SAMPLE_W-1:0] val, logic typed, logic [SAMPLE_W-1:0] want);
		while (!calm && $urandom_range(0, 99) < 12) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		sample_in   <= smp;
		entry_index <= idx;
		entry_value <= val;
		do @(posedge clk); while (in_stall);
		if (act == ACT_WRITE) begin
			if (idx <= TABLE_LAST)
				curve_pts[idx] = val;
		end else begin
			pending_shapes.push_back(typed ? want : shape_sample(smp));
		end
	endtask

	// Random transaction: mostly samples, some table writes, a few out-of-range writes
	task automatic offer_random();
		logic [SAMPLE_W-1:0] smp;
		logic [IDX_W-1:0]    idx;
		logic [SAMPLE_W-1:0] val;
		int                  pick;
		smp  = SAMPLE_W'($urandom);
		idx  = IDX_W'($urandom);
		val  = SAMPLE_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 3))
					0: smp = 16'h8000;
					1: smp = 16'h7FFF;
					2: smp = 16'h0000;
					default: smp = 16'hFFFF;
				endcase
			end
			offer_item(ACT_SHAPE, smp, idx, val, 1'b0, '0);
		end else begin
			if ($urandom_range(0, 9) != 0)
				idx = IDX_W'($urandom_range(0, TABLE_LAST));
			else
				idx = IDX_W'($urandom_range(TABLE_LAST + 1, 255));
			offer_item(ACT_WRITE, smp, idx, val, 1'b0, '0);
		end
	endtask

	// Drain the pipeline, then write the glitch register
	task automatic set_glitch(logic [GLITCH_W-1:0] amount);
		while (pending_shapes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid     <= 1'b1;
		glitch_amount <= amount;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		glitch_now  = amount;
	endtask

	// Output side: random stalls, one long hold-off on request
	initial begin : rx_side
		int  hold_left;
		bit  hold_taken;
		hold_left  = 0;
		hold_taken = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 12);
			end
		end
	end

	// Compare each accepted output with the oldest one owed
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_shapes.size() == 0) begin
				$display("%0t: unexpected output sample_out=%h", $time, sample_out);
				mismatches++;
			end else begin
				owed = pending_shapes.pop_front();
				if (sample_out !== owed) begin
					$display("%0t: sample_out mismatch expected=%h actual=%h",
						$time, owed, sample_out);
					mismatches++;
				end
			end
		end
	end

	// Main sequence: reset, stimulus table, random phases over glitch settings, wrap-up
	initial begin : main_seq
		int spin;
		load_reset_curve();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_ROWS; r++)
			offer_item(STIM_ROWS[r].act, STIM_ROWS[r].smp, STIM_ROWS[r].idx,
				STIM_ROWS[r].val, STIM_ROWS[r].typed, STIM_ROWS[r].want);
		in_valid <= 1'b0;

		for (int p = 0; p < N_PHASES; p++) begin
			set_glitch(GLITCH_PLAN[p]);
			calm = (p == 3);
			if (p == 5)
				hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++)
				offer_random();
			in_valid <= 1'b0;
		end
		calm = 1'b0;

		// Wait for the last outputs, then let the pipeline settle
		spin = 0;
		while (pending_shapes.size() != 0 && spin < 2000) begin
			@(posedge clk);
			spin++;
		end
		repeat (8) @(posedge clk);
		if (pending_shapes.size() != 0) begin
			$display("%0t: %0d outputs never arrived", $time, pending_shapes.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("interpolating_waveshaper regression: pass");
		else
			$display("interpolating_waveshaper regression: fail");
		$finish;
	end

	// Hard stop if the run hangs
	initial begin : watchdog
		#2_000_000;
		$display("%0t: timeout", $time);
		$display("interpolating_waveshaper regression: fail");
		$finish;
	end

endmodule

@@ interpolating_waveshaper.f @@
hw/rtl/iws_pkg.sv
hw/rtl/iws_table.sv
hw/rtl/iws_blend.sv
hw/rtl/interpolating_waveshaper.sv
tb/tb.sv
